// ===== src/vcfb_pkg.sv =====
// Shared types and constants for the virtual channel flit buffer.
package vcfb_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int QUEUE_DEPTH  = 16;
   localparam int FLIT_WIDTH   = 64;

   localparam int CH_W        = 3;                          // channel field
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = 5;                          // occupancy field
   localparam int STORE_DEPTH = MAX_CHANNELS * QUEUE_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CHIDX_W     = $clog2(MAX_CHANNELS);
   localparam int RSP_DATA_W  = 72;                         // flit, occupancy, padding

   localparam int CHAN_REG_W  = 4;
   localparam int LEVEL_REG_W = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic REG_CHANNELS   = 1'b0;
   localparam logic REG_FULL_LEVEL = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_PULL   = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_EMPTY = 2'd2,
      ERR_FULL  = 2'd3
   } err_type;

   typedef struct packed {
      err_type            error_code;
      logic [CNT_W-1:0]   occupancy;
      logic               is_full;
      logic               vc_empty;
      logic               use_ram;
   } status_type;

endpackage

// ===== src/vcfb_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module vcfb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/virtual_channel_flit_buffer.sv =====
// Virtual channel flit buffer: per-channel flit queues in one shared store.
// A request beat passes the store-read stage and then the response register before its result beat is valid.
// Throughput: one beat per cycle while the result side keeps up; a stalled result
// holds the request side once both stages are occupied.
// Reset clears all head pointers and fill counts; the store is not cleared.
// Registers reset to eight channels in use and a full level of sixteen.
module virtual_channel_flit_buffer (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = flit_in[63:0]; tuser = cmd[1:0], channel[4:2]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vcfb_pkg::FLIT_WIDTH-1:0]     req_tdata,
   input  logic [4:0]                          req_tuser,
   // response: tdata = flit_out[63:0], occupancy[68:64], zero[71:69];
   // tuser = error_code[1:0], is_full[2], vc_empty[3]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vcfb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [3:0]                          rsp_tuser,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vcfb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [vcfb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [vcfb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import vcfb_pkg::*;

   logic [CHAN_REG_W-1:0]  chan_reg_ff, chan_reg_in;
   logic [LEVEL_REG_W-1:0] level_reg_ff, level_reg_in;
   logic [SLOT_W-1:0]      head_ff [MAX_CHANNELS];
   logic [SLOT_W-1:0]      head_in [MAX_CHANNELS];
   logic [CNT_W-1:0]       fill_ff [MAX_CHANNELS];
   logic [CNT_W-1:0]       fill_in [MAX_CHANNELS];

   logic                   s1_valid_ff, s1_valid_in;
   status_type             s1_stat_ff, s1_stat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_stat_ff, rsp_stat_in;
   logic [FLIT_WIDTH-1:0]  rsp_flit_ff, rsp_flit_in;

   logic                   csr_wr;
   logic                   req_acc;
   logic                   out_free;
   logic [CHAN_REG_W-1:0]  active;
   logic [CHAN_REG_W-1:0]  new_active;
   logic [CNT_W-1:0]       level;
   cmd_type                cmd;
   logic [CH_W-1:0]        chan;
   logic [CHIDX_W-1:0]     chan_idx;
   logic [SLOT_W-1:0]      cur_head;
   logic [CNT_W-1:0]       cur_fill;
   logic [CNT_W-1:0]       new_fill;
   logic [SLOT_W-1:0]      new_head;

   logic                   ram_wr_en, ram_rd_en;
   logic [STORE_AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [FLIT_WIDTH-1:0]  ram_rd_data;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_CHANNELS:   csr_prdata = CSR_DATA_W'(chan_reg_ff);
         REG_FULL_LEVEL: csr_prdata = CSR_DATA_W'(level_reg_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign active = (chan_reg_ff > CHAN_REG_W'(MAX_CHANNELS)) ?
                   CHAN_REG_W'(MAX_CHANNELS) : chan_reg_ff;
   assign new_active = (csr_pwdata[CHAN_REG_W-1:0] > CHAN_REG_W'(MAX_CHANNELS)) ?
                       CHAN_REG_W'(MAX_CHANNELS) : csr_pwdata[CHAN_REG_W-1:0];
   assign level = (CNT_W'(level_reg_ff) > CNT_W'(QUEUE_DEPTH)) ?
                  CNT_W'(QUEUE_DEPTH) : CNT_W'(level_reg_ff);

   // handshake: the stage after the store read moves when the output slot frees
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_acc    = req_tvalid && req_tready;

   assign cmd      = cmd_type'(req_tuser[1:0]);
   assign chan     = req_tuser[4:2];
   assign chan_idx = CHIDX_W'(chan);
   assign cur_head = head_ff[chan_idx];
   assign cur_fill = fill_ff[chan_idx];

   always_comb begin
      chan_reg_in  = chan_reg_ff;
      level_reg_in = level_reg_ff;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         head_in[c] = head_ff[c];
         fill_in[c] = fill_ff[c];
      end
      s1_stat_in  = '0;
      new_fill    = cur_fill;
      new_head    = cur_head;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_addr = {chan_idx, SLOT_W'(cur_head + cur_fill[SLOT_W-1:0])};
      ram_rd_addr = {chan_idx, cur_head};

      if (req_acc) begin
         if (CHAN_REG_W'(chan) >= active) begin
            s1_stat_in.error_code = ERR_RANGE;
         end else begin
            s1_stat_in.error_code = ERR_NONE;
            case (cmd)
               CMD_PUSH: begin
                  if (cur_fill >= level) begin
                     s1_stat_in.error_code = ERR_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     new_fill  = cur_fill + CNT_W'(1);
                  end
               end
               CMD_PULL, CMD_PEEK: begin
                  if (cur_fill == '0) begin
                     s1_stat_in.error_code = ERR_EMPTY;
                  end else begin
                     ram_rd_en          = 1'b1;
                     s1_stat_in.use_ram = 1'b1;
                     if (cmd == CMD_PULL) begin
                        new_head = cur_head + SLOT_W'(1);
                        new_fill = cur_fill - CNT_W'(1);
                     end
                  end
               end
               default: ;
            endcase
            s1_stat_in.occupancy = new_fill;
            s1_stat_in.is_full   = new_fill >= level;
            s1_stat_in.vc_empty  = new_fill == '0;
            head_in[chan_idx]    = new_head;
            fill_in[chan_idx]    = new_fill;
         end
      end

      // the user must write only while idle, which the block does not enforce; shrinking empties the dropped channels
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_CHANNELS: begin
               chan_reg_in = csr_pwdata[CHAN_REG_W-1:0];
               for (int c = 0; c < MAX_CHANNELS; c++) begin
                  if (CHAN_REG_W'(c) >= new_active) begin
                     head_in[c] = '0;
                     fill_in[c] = '0;
                  end
               end
            end
            REG_FULL_LEVEL: level_reg_in = csr_pwdata[LEVEL_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_flit_in  = rsp_flit_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_stat_in = s1_stat_ff;
            rsp_flit_in = s1_stat_ff.use_ram ? ram_rd_data : '0;
         end
      end
      if (req_tready) begin
         s1_valid_in = req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_reg_ff  <= CHAN_REG_W'(MAX_CHANNELS);
         level_reg_ff <= LEVEL_REG_W'(QUEUE_DEPTH);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            head_ff[c] <= '0;
            fill_ff[c] <= '0;
         end
      end else begin
         chan_reg_ff  <= chan_reg_in;
         level_reg_ff <= level_reg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            head_ff[c] <= head_in[c];
            fill_ff[c] <= fill_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_stat_ff <= s1_stat_in;
      end
      rsp_stat_ff <= rsp_stat_in;
      rsp_flit_ff <= rsp_flit_in;
   end

   vcfb_ram #(
      .WIDTH (FLIT_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_stat_ff.occupancy, rsp_flit_ff};
   assign rsp_tuser  = {rsp_stat_ff.vc_empty, rsp_stat_ff.is_full, rsp_stat_ff.error_code};

   // store read data must hold while the beat behind it is stalled
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> $stable(ram_rd_data))
      else $error("store read data lost under stall");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_stat_ff.occupancy <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy beyond queue depth");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff.error_code == ERR_RANGE |->
         rsp_stat_ff.occupancy == '0 && !rsp_stat_ff.is_full &&
         !rsp_stat_ff.vc_empty && rsp_flit_ff == '0)
      else $error("out-of-range beat carries non-zero fields");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store read and write in the same cycle");

   a_ram_err: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_stat_ff.use_ram |-> s1_stat_ff.error_code == ERR_NONE)
      else $error("store read issued for a failed command");

endmodule
